@@ sv/rff_pkg.sv @@
// Shared types and constants for the report frame filter.
`timescale 1ns / 1ps

package rff_pkg;

  // Byte counter width, holds any frame size limit up to 255
  localparam int unsigned CntW = 8;

  // Frame layout
  localparam int unsigned MinHeaderLen = 15;
  localparam int unsigned MinReportLen = 27;
  localparam int unsigned AddrFirst    = 2;
  localparam int unsigned AddrLast     = 7;
  localparam int unsigned FieldFirst   = 8;
  localparam int unsigned FieldLast    = 26;
  localparam int unsigned FieldBytes   = FieldLast - FieldFirst + 1;

  // Register reset values
  localparam logic [7:0]  HeaderReset  = 8'h42;
  localparam logic [47:0] AddrReset    = 48'hAABB_CCCC_BBAA;
  localparam logic [7:0]  IdLowReset   = 8'd2;
  localparam logic [7:0]  IdHighReset  = 8'd9;

  // Register indexes (byte address / 8)
  localparam logic [1:0] RegHeader = 2'd0;
  localparam logic [1:0] RegAddr   = 2'd1;
  localparam logic [1:0] RegIdLow  = 2'd2;
  localparam logic [1:0] RegIdHigh = 2'd3;

  // Result queue depth
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StCrc      = 3'd1,
    StShortHdr = 3'd2,
    StHeader   = 3'd3,
    StAddress  = 3'd4,
    StShortRpt = 3'd5,
    StIdRange  = 3'd6
  } rff_status_e;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [47:0] device_address;
    logic [7:0]  node_id_min;
    logic [7:0]  node_id_max;
  } rff_cfg_t;

  typedef struct packed {
    rff_status_e        status;
    logic [7:0]         node_id;
    logic [7:0]         slot_num;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        icept_raw;
    logic [31:0]        slope_raw;
    logic signed [31:0] tdelta;
    logic [7:0]         next_channel;
    logic signed [7:0]  report_rssi;
  } rff_report_t;

endpackage

@@ sv/rff_front.sv @@
// Front end: counts and checks frame bytes, builds one report per frame.
`timescale 1ns / 1ps

module rff_front #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rff_pkg::rff_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_end_i,
  input  logic               crc_ok_i,
  input  logic signed [7:0]  signal_strength_i,
  input  logic               push_ready_i,
  output logic               push_o,
  output rff_pkg::rff_report_t report_o
);
  import rff_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FRAME_BYTES);

  logic [CntW-1:0] count_q, count_d, count_n;
  logic            header_bad_q, header_bad_d, header_bad_n;
  logic            address_bad_q, address_bad_d, address_bad_n;
  logic [7:0]      field_q [FieldBytes];
  logic [7:0]      field_n [FieldBytes];
  logic            accept, in_frame;
  logic [2:0]      addr_sel;
  logic [7:0]      addr_byte;
  rff_status_e     status;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign in_frame   = count_q < MaxCnt;

  // Expected address octet for positions 2..7
  assign addr_sel  = 3'(count_q - CntW'(AddrFirst));
  always_comb begin
    case (addr_sel)
      3'd0:    addr_byte = cfg_i.device_address[7:0];
      3'd1:    addr_byte = cfg_i.device_address[15:8];
      3'd2:    addr_byte = cfg_i.device_address[23:16];
      3'd3:    addr_byte = cfg_i.device_address[31:24];
      3'd4:    addr_byte = cfg_i.device_address[39:32];
      3'd5:    addr_byte = cfg_i.device_address[47:40];
      default: addr_byte = 8'h00;
    endcase
  end

  // Frame state after taking in the current byte
  always_comb begin
    count_n       = count_q;
    header_bad_n  = header_bad_q;
    address_bad_n = address_bad_q;
    for (int k = 0; k < FieldBytes; k++) begin
      field_n[k] = field_q[k];
    end
    if (in_frame) begin
      if (count_q == '0 && data_byte_i != cfg_i.header_byte) begin
        header_bad_n = 1'b1;
      end
      if (count_q >= CntW'(AddrFirst) && count_q <= CntW'(AddrLast) &&
          data_byte_i != addr_byte) begin
        address_bad_n = 1'b1;
      end
      for (int k = 0; k < FieldBytes; k++) begin
        if (count_q == CntW'(k + FieldFirst)) begin
          field_n[k] = data_byte_i;
        end
      end
      count_n = count_q + 1'b1;
    end
  end

  // Check order: crc, short header, header, address, short report, id range
  always_comb begin
    if (!crc_ok_i) begin
      status = StCrc;
    end else if (count_n < CntW'(MinHeaderLen)) begin
      status = StShortHdr;
    end else if (header_bad_n) begin
      status = StHeader;
    end else if (address_bad_n) begin
      status = StAddress;
    end else if (count_n < CntW'(MinReportLen)) begin
      status = StShortRpt;
    end else if (field_n[0] < cfg_i.node_id_min ||
                 field_n[0] > cfg_i.node_id_max) begin
      status = StIdRange;
    end else begin
      status = StOk;
    end
  end

  // Report record, fields zero unless accepted
  always_comb begin
    report_o        = '0;
    report_o.status = status;
    if (status == StOk) begin
      report_o.node_id      = field_n[0];
      report_o.slot_num     = field_n[1];
      report_o.pos_x        = {field_n[3], field_n[2]};
      report_o.pos_y        = {field_n[5], field_n[4]};
      report_o.icept_raw    = {field_n[9], field_n[8], field_n[7], field_n[6]};
      report_o.slope_raw    = {field_n[13], field_n[12], field_n[11], field_n[10]};
      report_o.tdelta       = {field_n[17], field_n[16], field_n[15], field_n[14]};
      report_o.next_channel = field_n[18];
      report_o.report_rssi  = signal_strength_i;
    end
  end

  assign push_o = accept & frame_end_i;

  // Next frame state, cleared at frame end
  always_comb begin
    count_d       = count_q;
    header_bad_d  = header_bad_q;
    address_bad_d = address_bad_q;
    if (accept) begin
      if (frame_end_i) begin
        count_d       = '0;
        header_bad_d  = 1'b0;
        address_bad_d = 1'b0;
      end else begin
        count_d       = count_n;
        header_bad_d  = header_bad_n;
        address_bad_d = address_bad_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      header_bad_q  <= 1'b0;
      address_bad_q <= 1'b0;
    end else begin
      count_q       <= count_d;
      header_bad_q  <= header_bad_d;
      address_bad_q <= address_bad_d;
    end
  end

  // Captured report bytes; a frame that reaches OK rewrites all of them
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < FieldBytes; k++) begin
        field_q[k] <= field_n[k];
      end
    end
  end

endmodule

@@ sv/rff_queue.sv @@
// Back end: short report queue whose head drives the result channel.
`timescale 1ns / 1ps

module rff_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 push_ready_o,
  input  rff_pkg::rff_report_t push_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rff_pkg::rff_report_t out_data_o
);
  import rff_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntQW = $clog2(QueueDepth + 1);

  rff_report_t      mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o  = cnt_q != '0;
  assign pop          = out_valid_o & out_ready_i;
  assign push_ready_o = (cnt_q != CntQW'(QueueDepth)) | pop;
  assign out_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/report_frame_filter_extract.sv @@
// Top level: config registers, frame checker front end, report queue.
// A report is written into the report queue when its frame_end byte is accepted.
// Throughput: one byte per cycle; the front end stalls only when the
// two-entry report queue is full and its head is not being taken.
// Reset (rst_ni, async, active low) restores register defaults, clears the
// frame counter and check flags and empties the queue; no clearing pass.
`timescale 1ns / 1ps

module report_frame_filter_extract #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // Byte input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_end_i,
  input  logic               crc_ok_i,
  input  logic signed [7:0]  signal_strength_i,
  // Report output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [7:0]         node_id_o,
  output logic [7:0]         slot_num_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic [31:0]        icept_raw_o,
  output logic [31:0]        slope_raw_o,
  output logic signed [31:0] tdelta_o,
  output logic [7:0]         next_channel_o,
  output logic signed [7:0]  report_rssi_o
);
  import rff_pkg::*;

  rff_cfg_t    cfg_q, cfg_d;
  logic [1:0]  reg_sel;
  logic        wr_en;
  logic        push, push_ready;
  rff_report_t push_data, head;

  // Register file, 8-byte stride
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        RegHeader: cfg_d.header_byte    = pwdata[7:0];
        RegAddr:   cfg_d.device_address = pwdata[47:0];
        RegIdLow:  cfg_d.node_id_min    = pwdata[7:0];
        RegIdHigh: cfg_d.node_id_max    = pwdata[7:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegHeader: prdata = {56'd0, cfg_q.header_byte};
      RegAddr:   prdata = {16'd0, cfg_q.device_address};
      RegIdLow:  prdata = {56'd0, cfg_q.node_id_min};
      RegIdHigh: prdata = {56'd0, cfg_q.node_id_max};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte    <= HeaderReset;
      cfg_q.device_address <= AddrReset;
      cfg_q.node_id_min    <= IdLowReset;
      cfg_q.node_id_max    <= IdHighReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rff_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i             (cfg_q),
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .frame_end_i,
    .crc_ok_i,
    .signal_strength_i,
    .push_ready_i      (push_ready),
    .push_o            (push),
    .report_o          (push_data)
  );

  rff_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .out_valid_o,
    .out_ready_i,
    .out_data_o   (head)
  );

  // Unpack the head report onto the result ports
  assign status_o       = head.status;
  assign node_id_o      = head.node_id;
  assign slot_num_o     = head.slot_num;
  assign pos_x_o        = head.pos_x;
  assign pos_y_o        = head.pos_y;
  assign icept_raw_o    = head.icept_raw;
  assign slope_raw_o    = head.slope_raw;
  assign tdelta_o       = head.tdelta;
  assign next_channel_o = head.next_channel;
  assign report_rssi_o  = head.report_rssi;

endmodule

@@ sim/report_frame_filter_extract_tb.sv @@
// Self-checking testbench for the report frame filter: random frames, APB setup, scoreboard.
`timescale 1ns / 1ps

// Scoreboard: tracks the frame being received and holds the reports it must produce
class report_scoreboard;
  // register copy
  logic [7:0]  hdr_reg;
  logic [47:0] addr_reg;
  logic [7:0]  id_lo_reg;
  logic [7:0]  id_hi_reg;
  // frame state
  int unsigned max_bytes;
  int unsigned count;
  bit          hdr_bad;
  bit          addr_bad;
  logic [7:0]  kept[rff_pkg::MinReportLen];
  // pending reports, oldest first
  rff_pkg::rff_report_t report_q[$];
  // statistics
  int unsigned errors;
  int unsigned bytes_seen;
  int unsigned reports_seen;
  int unsigned status_hits[7];

  function new(int unsigned max_frame);
    max_bytes = max_frame;
    hdr_reg   = rff_pkg::HeaderReset;
    addr_reg  = rff_pkg::AddrReset;
    id_lo_reg = rff_pkg::IdLowReset;
    id_hi_reg = rff_pkg::IdHighReset;
    clear_frame();
  endfunction

  function void clear_frame();
    count    = 0;
    hdr_bad  = 0;
    addr_bad = 0;
    foreach (kept[i]) kept[i] = '0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      rff_pkg::RegHeader: hdr_reg   = val[7:0];
      rff_pkg::RegAddr:   addr_reg  = val[47:0];
      rff_pkg::RegIdLow:  id_lo_reg = val[7:0];
      rff_pkg::RegIdHigh: id_hi_reg = val[7:0];
      default: ;
    endcase
  endfunction

  // accepted input transaction
  function void note_byte(logic [7:0] b, bit last, bit crc, logic [7:0] rssi);
    rff_pkg::rff_report_t rep;
    rff_pkg::rff_status_e st;
    bytes_seen++;
    // bytes past the saturation point are dropped, compares included
    if (count < max_bytes) begin
      if (count == 0 && b != hdr_reg) hdr_bad = 1;
      if (count >= rff_pkg::AddrFirst && count <= rff_pkg::AddrLast)
        if (b != addr_reg[8*(count-rff_pkg::AddrFirst) +: 8]) addr_bad = 1;
      if (count < rff_pkg::MinReportLen) kept[count] = b;
      count++;
    end
    if (!last) return;
    // first failing check wins
    if (!crc)                                 st = rff_pkg::StCrc;
    else if (count < rff_pkg::MinHeaderLen)   st = rff_pkg::StShortHdr;
    else if (hdr_bad)                         st = rff_pkg::StHeader;
    else if (addr_bad)                        st = rff_pkg::StAddress;
    else if (count < rff_pkg::MinReportLen)   st = rff_pkg::StShortRpt;
    else if (kept[8] < id_lo_reg || kept[8] > id_hi_reg) st = rff_pkg::StIdRange;
    else                                      st = rff_pkg::StOk;
    rep = '0;
    rep.status = st;
    if (st == rff_pkg::StOk) begin
      rep.node_id      = kept[8];
      rep.slot_num     = kept[9];
      rep.pos_x        = {kept[11], kept[10]};
      rep.pos_y        = {kept[13], kept[12]};
      rep.icept_raw    = {kept[17], kept[16], kept[15], kept[14]};
      rep.slope_raw    = {kept[21], kept[20], kept[19], kept[18]};
      rep.tdelta       = {kept[25], kept[24], kept[23], kept[22]};
      rep.next_channel = kept[26];
      rep.report_rssi  = rssi;
    end
    report_q.push_back(rep);
    status_hits[st]++;
    clear_frame();
  endfunction

  function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // accepted output transaction
  function void check_report(rff_pkg::rff_report_t got);
    rff_pkg::rff_report_t exp_r;
    if (report_q.size() == 0) begin
      $display("%0t: unexpected report: expected none, got status %0d", $time, got.status);
      errors++;
      return;
    end
    exp_r = report_q.pop_front();
    reports_seen++;
    check_field("status",       exp_r.status,       got.status);
    check_field("node_id",      exp_r.node_id,      got.node_id);
    check_field("slot_num",     exp_r.slot_num,     got.slot_num);
    check_field("pos_x",        exp_r.pos_x,        got.pos_x);
    check_field("pos_y",        exp_r.pos_y,        got.pos_y);
    check_field("icept_raw",    exp_r.icept_raw,    got.icept_raw);
    check_field("slope_raw",    exp_r.slope_raw,    got.slope_raw);
    check_field("tdelta",       exp_r.tdelta,       got.tdelta);
    check_field("next_channel", exp_r.next_channel, got.next_channel);
    check_field("report_rssi",  exp_r.report_rssi,  got.report_rssi);
  endfunction
endclass

module report_frame_filter_extract_tb;
  import rff_pkg::*;

  localparam int unsigned MaxFrame = 128;

  typedef enum {
    FrGood, FrCrcBad, FrTiny, FrBadHeader, FrBadAddr, FrShortRpt, FrBadId, FrNoise, FrLong
  } frame_kind_e;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               frame_end_i;
  logic               crc_ok_i;
  logic signed [7:0]  signal_strength_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         status_o;
  logic [7:0]         node_id_o;
  logic [7:0]         slot_num_o;
  logic signed [15:0] pos_x_o;
  logic signed [15:0] pos_y_o;
  logic [31:0]        icept_raw_o;
  logic [31:0]        slope_raw_o;
  logic signed [31:0] tdelta_o;
  logic [7:0]         next_channel_o;
  logic signed [7:0]  report_rssi_o;

  report_scoreboard  sb;
  logic [7:0]        frame_buf[$];
  rff_report_t       got_rep;
  bit                in_calm;
  bit                out_calm;

  report_frame_filter_extract #(
    .MAX_FRAME_BYTES(MaxFrame)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .frame_end_i,
    .crc_ok_i,
    .signal_strength_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .node_id_o,
    .slot_num_o,
    .pos_x_o,
    .pos_y_o,
    .icept_raw_o,
    .slope_raw_o,
    .tdelta_o,
    .next_channel_o,
    .report_rssi_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("report_frame_filter_extract_tb NOT OK");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver side backpressure
  initial begin
    int unsigned g;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      g = gap_len(out_calm);
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // report monitor, sampled mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_rep.status       = rff_status_e'(status_o);
      got_rep.node_id      = node_id_o;
      got_rep.slot_num     = slot_num_o;
      got_rep.pos_x        = pos_x_o;
      got_rep.pos_y        = pos_y_o;
      got_rep.icept_raw    = icept_raw_o;
      got_rep.slope_raw    = slope_raw_o;
      got_rep.tdelta       = tdelta_o;
      got_rep.next_channel = next_channel_o;
      got_rep.report_rssi  = report_rssi_o;
      sb.check_report(got_rep);
    end
  end

  // one byte transaction, returns on the accepting edge
  task automatic send_byte(logic [7:0] b, bit last, bit crc, logic [7:0] rssi);
    int unsigned g;
    bit          acc;
    g = gap_len(in_calm);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    data_byte_i       <= b;
    frame_end_i       <= last;
    crc_ok_i          <= crc;
    signal_strength_i <= rssi;
    do begin
      @(negedge clk_i);
      acc = in_ready_o;
      @(posedge clk_i);
    end while (!acc);
    sb.note_byte(b, last, crc, rssi);
  endtask

  // send frame_buf; CRC and RSSI on non-final bytes are don't-care, so randomize them
  task automatic send_buf(bit crc, logic [7:0] rssi);
    for (int i = 0; i < frame_buf.size(); i++) begin
      if (i == frame_buf.size() - 1) send_byte(frame_buf[i], 1'b1, crc, rssi);
      else send_byte(frame_buf[i], 1'b0, 1'($urandom), 8'($urandom));
    end
  endtask

  function automatic logic [7:0] id_inside();
    if (sb.id_lo_reg <= sb.id_hi_reg) return 8'($urandom_range(sb.id_hi_reg, sb.id_lo_reg));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] id_outside();
    if (sb.id_lo_reg > sb.id_hi_reg) return 8'($urandom);
    if (sb.id_lo_reg > 0 && (sb.id_hi_reg == 8'hFF || $urandom_range(0, 1) == 0))
      return 8'($urandom_range(0, sb.id_lo_reg - 1));
    if (sb.id_hi_reg < 8'hFF) return 8'($urandom_range(sb.id_hi_reg + 1, 255));
    return 8'($urandom);
  endfunction

  // well-formed frame with random content, then the flaw the kind asks for
  task automatic build_frame(frame_kind_e kind, int unsigned len);
    int unsigned pos;
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    if (kind == FrNoise) return;
    frame_buf[0] = sb.hdr_reg;
    for (int i = AddrFirst; i <= AddrLast && i < len; i++)
      frame_buf[i] = sb.addr_reg[8*(i-AddrFirst) +: 8];
    if (len > 8) frame_buf[8] = id_inside();
    case (kind)
      FrBadHeader: frame_buf[0] ^= 8'($urandom_range(1, 255));
      FrBadAddr: begin
        if (len > AddrFirst) begin
          pos = $urandom_range(AddrFirst, (len - 1 < AddrLast) ? len - 1 : AddrLast);
          frame_buf[pos] ^= 8'($urandom_range(1, 255));
        end
      end
      FrBadId: if (len > 8) frame_buf[8] = id_outside();
      default: ;
    endcase
  endtask

  task automatic random_frame();
    int unsigned r;
    frame_kind_e kind;
    int unsigned len;
    bit          crc;
    r = $urandom_range(0, 99);
    if (r < 55)      kind = FrGood;
    else if (r < 62) kind = FrCrcBad;
    else if (r < 69) kind = FrTiny;
    else if (r < 75) kind = FrBadHeader;
    else if (r < 82) kind = FrBadAddr;
    else if (r < 89) kind = FrShortRpt;
    else if (r < 95) kind = FrBadId;
    else if (r < 99) kind = FrNoise;
    else             kind = FrLong;
    case (kind)
      FrGood:     len = ($urandom_range(0, 99) < 85) ? $urandom_range(27, 34)
                                                     : $urandom_range(35, 64);
      FrCrcBad:   len = $urandom_range(1, 40);
      FrTiny:     len = $urandom_range(1, 14);
      FrShortRpt: len = $urandom_range(15, 26);
      FrBadId:    len = $urandom_range(27, 34);
      FrNoise:    len = $urandom_range(1, 40);
      FrLong:     len = $urandom_range(MaxFrame + 1, MaxFrame + 22);
      default:    len = $urandom_range(15, 34);
    endcase
    build_frame(kind, len);
    if (kind == FrCrcBad)     crc = 1'b0;
    else if (kind == FrNoise) crc = 1'($urandom);
    else                      crc = 1'b1;
    send_buf(crc, 8'($urandom));
  endtask

  task automatic random_phase(int unsigned n_bytes);
    int unsigned start;
    start = sb.bytes_seen;
    while (sb.bytes_seen - start < n_bytes) random_frame();
  endtask

  // let every pending report drain before touching registers or ending
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    bit rdy;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(logic [7:0] hdr, logic [47:0] addr, logic [7:0] lo, logic [7:0] hi);
    drain();
    reg_write(RegHeader, {56'b0, hdr});
    reg_write(RegAddr,   {16'b0, addr});
    reg_write(RegIdLow,  {56'b0, lo});
    reg_write(RegIdHigh, {56'b0, hi});
  endtask

  // main sequence
  initial begin
    logic [7:0] lo;
    sb = new(MaxFrame);
    in_calm            = 1'b0;
    out_calm           = 1'b0;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_valid_i        <= 1'b0;
    data_byte_i       <= '0;
    frame_end_i       <= 1'b0;
    crc_ok_i          <= 1'b0;
    signal_strength_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: accepted report at the low id, minimum positions, lowest RSSI
    build_frame(FrGood, 27);
    for (int i = 9; i < 27; i++) frame_buf[i] = 8'h00;
    frame_buf[11] = 8'h80;
    frame_buf[13] = 8'h80;
    frame_buf[25] = 8'h80;
    frame_buf[8]  = sb.id_lo_reg;
    send_buf(1'b1, 8'h80);
    // accepted report at the high id, all-ones fields, top positive values
    build_frame(FrGood, 30);
    for (int i = 9; i < 30; i++) frame_buf[i] = 8'hFF;
    frame_buf[11] = 8'h7F;
    frame_buf[13] = 8'h7F;
    frame_buf[25] = 8'h7F;
    frame_buf[8]  = sb.id_hi_reg;
    send_buf(1'b1, 8'h7F);
    // each rejection in turn
    build_frame(FrGood, 27);
    send_buf(1'b0, 8'h00);
    build_frame(FrGood, 1);
    send_buf(1'b1, 8'h01);
    build_frame(FrGood, 14);
    send_buf(1'b1, 8'hF0);
    build_frame(FrBadHeader, 15);
    send_buf(1'b1, 8'h10);
    build_frame(FrBadAddr, 20);
    send_buf(1'b1, 8'h20);
    build_frame(FrShortRpt, 26);
    send_buf(1'b1, 8'h30);
    build_frame(FrGood, 27);
    frame_buf[8] = 8'(sb.id_hi_reg + 1);
    send_buf(1'b1, 8'h40);
    // long frame: counter saturates, tail ignored, still closes on frame_end
    build_frame(FrGood, MaxFrame + 12);
    send_buf(1'b1, 8'hC5);

    // random phases over several register settings
    random_phase(240);
    set_config(8'h00, 48'h0, 8'h00, 8'hFF);
    random_phase(240);
    // empty id range, no idling on either side
    set_config(8'hFF, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'h00);
    in_calm  = 1'b1;
    out_calm = 1'b1;
    random_phase(230);
    lo = 8'($urandom);
    set_config(8'($urandom), {16'($urandom), 32'($urandom)}, lo, lo);
    in_calm  = 1'b0;
    out_calm = 1'b0;
    random_phase(230);
    lo = 8'($urandom_range(0, 200));
    set_config(8'($urandom), {16'($urandom), 32'($urandom)}, lo, 8'($urandom_range(lo, 255)));
    random_phase(240);

    drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d reports across five register settings",
             sb.bytes_seen, sb.reports_seen);
    $display("Status mix ok/crc/short/header/address/short-report/id: %0d %0d %0d %0d %0d %0d %0d",
             sb.status_hits[StOk], sb.status_hits[StCrc], sb.status_hits[StShortHdr],
             sb.status_hits[StHeader], sb.status_hits[StAddress],
             sb.status_hits[StShortRpt], sb.status_hits[StIdRange]);
    if (sb.errors == 0) begin
      $display("report_frame_filter_extract_tb OK");
    end else begin
      $display("report_frame_filter_extract_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ report_frame_filter_extract.f @@
sv/rff_pkg.sv
sv/rff_front.sv
sv/rff_queue.sv
sv/report_frame_filter_extract.sv
sim/report_frame_filter_extract_tb.sv
